/* rtl/lwr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwr_pkg
// Shared types and constants of the limited word replace stream unit.
// ----------------------------------------------------------------------------
package lwr_pkg;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CHAR_WIDTH     = 8;
   localparam int PLEN_WIDTH     = 4;
   localparam int RLEN_WIDTH     = 5;
   localparam int LIMIT_REG_WIDTH = 17;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      REG_PATTERN_BYTES   = 3'd0,
      REG_PATTERN_LEN     = 3'd1,
      REG_REPLACEMENT_LO  = 3'd2,
      REG_REPLACEMENT_HI  = 3'd3,
      REG_REPLACEMENT_LEN = 3'd4,
      REG_REPLACE_LIMIT   = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PASS,
      ST_REPL,
      ST_END,
      ST_TERM,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      SEL_QUEUE,
      SEL_REPL,
      SEL_TERM
   } emit_sel_type;

   typedef struct packed {
      logic         load;
      logic         shift;
      logic         emit;
      emit_sel_type sel;
      logic         rep_step;
      logic         count_inc;
      logic         clear_q;
      logic         clear_count;
      logic         finish;
   } dp_cmd_type;

   typedef struct packed {
      logic bypass;
      logic match_full;
      logic match_part;
      logic qn_one;
      logic qn_zero;
      logic eos;
      logic rep_last;
      logic rlen_zero;
   } dp_status_type;

   typedef struct packed {
      logic                  emit;
      logic                  finish;
      logic [CHAR_WIDTH-1:0] ch;
      logic                  term;
   } out_cmd_type;

endpackage

/* rtl/limited_word_replace_stream_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limited_word_replace_stream_unit
// Streaming find-and-replace of a short match word in a byte string.
// ----------------------------------------------------------------------------
// Each request carries one text byte; tlast marks the last byte of a string.
// Results are bytes on rsp_tdata, with rsp_tuser set on the terminator that
// closes each string and rsp_tlast set on the last result of each request
// (a request that only extends a partial match gives no result). A byte
// dropped from the match buffer on a mismatch leaves straight from the scan
// state. The controller emits one byte per cycle while the output side has
// room, through a one-deep hold slot into the response register, and a new
// request is taken only once the previous one is wrapped up. Configuration
// registers must be written only while idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module limited_word_replace_stream_unit
   import lwr_pkg::*;
#(
   parameter int PATTERN_MAX     = 8,
   parameter int REPLACEMENT_MAX = 16,
   parameter int LIMIT_WIDTH     = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration write port
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] in_char
   input  logic                      req_tlast,   // end_of_string
   // response channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // [7:0] out_char
   output logic                      rsp_tuser,   // [0] is_terminator
   output logic                      rsp_tlast    // last_of_run
);

   dp_cmd_type            cmd;
   dp_status_type         st;
   out_cmd_type           ocmd;
   logic                  slot_ready;
   logic [CHAR_WIDTH-1:0] emit_char;
   logic                  emit_term;

   lwr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .slot_ready (slot_ready),
      .cmd        (cmd)
   );

   lwr_dp #(
      .PATTERN_MAX     (PATTERN_MAX),
      .REPLACEMENT_MAX (REPLACEMENT_MAX),
      .LIMIT_WIDTH     (LIMIT_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .in_char   (req_tdata),
      .in_eos    (req_tlast),
      .cmd       (cmd),
      .st        (st),
      .emit_char (emit_char),
      .emit_term (emit_term)
   );

   always_comb begin
      ocmd.emit   = cmd.emit;
      ocmd.finish = cmd.finish;
      ocmd.ch     = emit_char;
      ocmd.term   = emit_term;
   end

   lwr_out u_out (
      .clock      (clock),
      .reset      (reset),
      .ocmd       (ocmd),
      .slot_ready (slot_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/lwr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwr_ctrl
// Controller: walks one request through scan, pass, replace, flush and
// terminator steps, one result per cycle when the output side has room.
// ----------------------------------------------------------------------------
module lwr_ctrl
   import lwr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type st,
   input  logic          slot_ready,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.sel    = SEL_QUEUE;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (st.bypass) begin
               state_in = ST_PASS;
            end else if (st.match_full) begin
               cmd.count_inc = 1'b1;
               cmd.clear_q   = 1'b1;
               state_in      = st.rlen_zero ? ST_END : ST_REPL;
            end else if (st.match_part) begin
               state_in = ST_END;
            end else if (slot_ready) begin
               // mismatch: release oldest byte, rescan from the next
               cmd.emit  = 1'b1;
               cmd.shift = 1'b1;
               if (st.qn_one) begin
                  state_in = ST_END;
               end
            end
         end
         ST_PASS: begin
            if (slot_ready) begin
               cmd.emit  = 1'b1;
               cmd.shift = 1'b1;
               if (st.qn_one) begin
                  state_in = ST_END;
               end
            end
         end
         ST_REPL: begin
            if (slot_ready) begin
               cmd.emit     = 1'b1;
               cmd.sel      = SEL_REPL;
               cmd.rep_step = 1'b1;
               if (st.rep_last) begin
                  state_in = ST_END;
               end
            end
         end
         ST_END: begin
            if (!st.eos) begin
               state_in = ST_FIN;
            end else if (st.qn_zero) begin
               state_in = ST_TERM;
            end else begin
               state_in = ST_PASS;
            end
         end
         ST_TERM: begin
            if (slot_ready) begin
               cmd.emit        = 1'b1;
               cmd.sel         = SEL_TERM;
               cmd.clear_q     = 1'b1;
               cmd.clear_count = 1'b1;
               state_in        = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/lwr_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwr_dp
// Datapath: configuration registers, byte queue with match compare,
// replacement index and replacement counter.
// ----------------------------------------------------------------------------
module lwr_dp
   import lwr_pkg::*;
#(
   parameter int PATTERN_MAX     = 8,
   parameter int REPLACEMENT_MAX = 16,
   parameter int LIMIT_WIDTH     = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   input  logic [CHAR_WIDTH-1:0]     in_char,
   input  logic                      in_eos,
   input  dp_cmd_type                cmd,
   output dp_status_type             st,
   output logic [CHAR_WIDTH-1:0]     emit_char,
   output logic                      emit_term
);

   localparam int QNW = $clog2(PATTERN_MAX + 1);
   localparam int RIW = $clog2(REPLACEMENT_MAX + 1);
   localparam int CW  = (LIMIT_WIDTH > 16) ? LIMIT_WIDTH : 16;

   // configuration
   logic [63:0]                  pattern_bytes_ff, pattern_bytes_in;
   logic [PLEN_WIDTH-1:0]        pattern_len_ff, pattern_len_in;
   logic [63:0]                  replacement_lo_ff, replacement_lo_in;
   logic [63:0]                  replacement_hi_ff, replacement_hi_in;
   logic [RLEN_WIDTH-1:0]        replacement_len_ff, replacement_len_in;
   logic [LIMIT_REG_WIDTH-1:0]   replace_limit_ff, replace_limit_in;

   // working state
   logic [CHAR_WIDTH-1:0]  q_ff [PATTERN_MAX];
   logic [CHAR_WIDTH-1:0]  q_in [PATTERN_MAX];
   logic [CHAR_WIDTH-1:0]  q_next_lane [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] lane_ok;
   logic [QNW-1:0]         qn_ff, qn_in;
   logic                   eos_ff, eos_in;
   logic [RIW-1:0]         rep_idx_ff, rep_idx_in;
   logic [LIMIT_WIDTH-1:0] done_ff, done_in;

   logic [QNW-1:0]         plen_eff;
   logic [RIW-1:0]         rlen_eff;
   logic [127:0]           rep_all;
   logic                   limit_ok;
   logic                   match_all;
   logic [CW-1:0]          done_ext;
   logic [CW-1:0]          limit_ext;

   csr_index_type csr_idx;
   assign csr_idx = csr_index_type'(csr_addr);

   always_comb begin
      pattern_bytes_in   = pattern_bytes_ff;
      pattern_len_in     = pattern_len_ff;
      replacement_lo_in  = replacement_lo_ff;
      replacement_hi_in  = replacement_hi_ff;
      replacement_len_in = replacement_len_ff;
      replace_limit_in   = replace_limit_ff;
      if (csr_we) begin
         case (csr_idx)
            REG_PATTERN_BYTES:   pattern_bytes_in   = csr_wdata;
            REG_PATTERN_LEN:     pattern_len_in     = csr_wdata[PLEN_WIDTH-1:0];
            REG_REPLACEMENT_LO:  replacement_lo_in  = csr_wdata;
            REG_REPLACEMENT_HI:  replacement_hi_in  = csr_wdata;
            REG_REPLACEMENT_LEN: replacement_len_in = csr_wdata[RLEN_WIDTH-1:0];
            REG_REPLACE_LIMIT:   replace_limit_in   = csr_wdata[LIMIT_REG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // effective lengths, clamped to the storage sizes
   assign plen_eff = (pattern_len_ff > PLEN_WIDTH'(PATTERN_MAX)) ?
                     QNW'(PATTERN_MAX) : QNW'(pattern_len_ff);
   assign rlen_eff = (replacement_len_ff > RLEN_WIDTH'(REPLACEMENT_MAX)) ?
                     RIW'(REPLACEMENT_MAX) : RIW'(replacement_len_ff);
   assign rep_all  = {replacement_hi_ff, replacement_lo_ff};

   // negative limit means unlimited
   assign done_ext  = CW'(done_ff);
   assign limit_ext = CW'(replace_limit_ff[15:0]);
   assign limit_ok  = replace_limit_ff[LIMIT_REG_WIDTH-1] || (done_ext < limit_ext);

   genvar gi;
   generate
      for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_lane
         if (gi < PATTERN_MAX - 1) begin : g_mid
            assign q_next_lane[gi] = q_ff[gi+1];
         end else begin : g_top
            assign q_next_lane[gi] = q_ff[gi];
         end

         // lanes at or past the fill level always agree
         assign lane_ok[gi] = (QNW'(gi) >= qn_ff) ||
                              (q_ff[gi] == pattern_bytes_ff[8*gi +: 8]);

         always_comb begin
            q_in[gi] = q_ff[gi];
            if (cmd.load && (qn_ff == QNW'(gi))) begin
               q_in[gi] = in_char;
            end else if (cmd.shift) begin
               q_in[gi] = q_next_lane[gi];
            end
         end

         always_ff @(posedge clock) begin
            q_ff[gi] <= q_in[gi];
         end
      end
   endgenerate

   assign match_all = &lane_ok;

   always_comb begin
      qn_in      = qn_ff;
      eos_in     = eos_ff;
      rep_idx_in = rep_idx_ff;
      done_in    = done_ff;
      if (cmd.load) begin
         qn_in      = qn_ff + QNW'(1);
         eos_in     = in_eos;
         rep_idx_in = '0;
      end
      if (cmd.shift) begin
         qn_in = qn_ff - QNW'(1);
      end
      if (cmd.clear_q) begin
         qn_in = '0;
      end
      if (cmd.rep_step) begin
         rep_idx_in = rep_idx_ff + RIW'(1);
      end
      if (cmd.count_inc && (done_ff != '1)) begin
         done_in = done_ff + LIMIT_WIDTH'(1);
      end
      if (cmd.clear_count) begin
         done_in = '0;
         eos_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff   <= '0;
         pattern_len_ff     <= '0;
         replacement_lo_ff  <= '0;
         replacement_hi_ff  <= '0;
         replacement_len_ff <= '0;
         replace_limit_ff   <= '1;
         qn_ff              <= '0;
         eos_ff             <= 1'b0;
         rep_idx_ff         <= '0;
         done_ff            <= '0;
      end else begin
         pattern_bytes_ff   <= pattern_bytes_in;
         pattern_len_ff     <= pattern_len_in;
         replacement_lo_ff  <= replacement_lo_in;
         replacement_hi_ff  <= replacement_hi_in;
         replacement_len_ff <= replacement_len_in;
         replace_limit_ff   <= replace_limit_in;
         qn_ff              <= qn_in;
         eos_ff             <= eos_in;
         rep_idx_ff         <= rep_idx_in;
         done_ff            <= done_in;
      end
   end

   always_comb begin
      st.bypass     = (plen_eff == '0) || (qn_ff > plen_eff) || !limit_ok;
      st.match_full = match_all && (qn_ff == plen_eff);
      st.match_part = match_all && (qn_ff < plen_eff);
      st.qn_one     = (qn_ff == QNW'(1));
      st.qn_zero    = (qn_ff == '0);
      st.eos        = eos_ff;
      st.rep_last   = (rep_idx_ff == rlen_eff - RIW'(1));
      st.rlen_zero  = (rlen_eff == '0);
   end

   always_comb begin
      emit_term = 1'b0;
      case (cmd.sel)
         SEL_QUEUE: emit_char = q_ff[0];
         SEL_REPL:  emit_char = rep_all[8*rep_idx_ff +: 8];
         SEL_TERM: begin
            emit_char = '0;
            emit_term = 1'b1;
         end
         default:   emit_char = q_ff[0];
      endcase
   end

endmodule

/* rtl/lwr_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwr_out
// Result stage: a one-deep hold slot that learns whether a byte is the last
// of its request, followed by the registered response channel.
// ----------------------------------------------------------------------------
module lwr_out
   import lwr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  out_cmd_type           ocmd,
   output logic                  slot_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [CHAR_WIDTH-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic                  hold_valid_ff, hold_valid_in;
   logic [CHAR_WIDTH-1:0] hold_char_ff, hold_char_in;
   logic                  hold_term_ff, hold_term_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0] rsp_char_ff, rsp_char_in;
   logic                  rsp_term_ff, rsp_term_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  out_free;
   logic                  push;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign slot_ready = !hold_valid_ff || out_free;
   assign push       = hold_valid_ff && (ocmd.emit || ocmd.finish);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_char_in  = hold_char_ff;
      hold_term_in  = hold_term_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_term_in   = rsp_term_ff;
      rsp_last_in   = rsp_last_ff;
      if (push) begin
         // the held byte is last only when the request finishes behind it
         rsp_valid_in = 1'b1;
         rsp_char_in  = hold_char_ff;
         rsp_term_in  = hold_term_ff;
         rsp_last_in  = ocmd.finish;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ocmd.emit) begin
         hold_valid_in = 1'b1;
         hold_char_in  = ocmd.ch;
         hold_term_in  = ocmd.term;
      end else if (ocmd.finish) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_char_ff <= hold_char_in;
      hold_term_ff <= hold_term_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_term_ff  <= rsp_term_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = rsp_term_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_emit_has_room : assert property (@(posedge clock) disable iff (reset)
      ocmd.emit |-> slot_ready)
      else $error("byte emitted while hold slot and response are both full");

   a_finish_has_room : assert property (@(posedge clock) disable iff (reset)
      ocmd.finish |-> slot_ready)
      else $error("request finished while response is blocked");

   a_emit_finish_apart : assert property (@(posedge clock) disable iff (reset)
      !(ocmd.emit && ocmd.finish))
      else $error("emit and finish in the same cycle");

   a_term_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("terminator not marked as last of its request");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the limited word replace stream unit.
// ----------------------------------------------------------------------------
// Streams text bytes through the unit and checks every response byte against
// an in-bench prediction of the find-and-replace behavior. Directed strings
// cover pass-through after reset, restart matching, the end-of-string flush,
// replacement limits, the longest match word and replacement, and a word
// shortened while bytes are held. Random phases then mix configurations with
// text built mostly from the match word. Both sides of the stream stall at
// random, except in the closing part of the run.
// ----------------------------------------------------------------------------
module tb;
   import lwr_pkg::*;

   localparam int     MAX_REPORTS    = 10;
   localparam int     SETTLE_CYCLES  = 32;
   localparam int     DRAIN_LIMIT    = 20000;
   localparam int     DONE_MAX       = 65535;
   localparam longint TIMEOUT_NS     = 64'd30_000_000;
   localparam logic [CSR_ADDR_WIDTH-1:0] SPARE_INDEX_LO = 3'd6;
   localparam logic [CSR_ADDR_WIDTH-1:0] SPARE_INDEX_HI = 3'd7;
   localparam logic [16:0] LIMIT_NONE     = 17'h1FFFF;
   localparam logic [16:0] LIMIT_MOST_NEG = 17'h10000;
   localparam logic [16:0] LIMIT_CEILING  = 17'h0FFFF;

   typedef struct packed {
      logic [7:0] ch;
      logic       term;
      logic       last;
   } text_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = '0;
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;
   logic                      rsp_tuser;
   logic                      rsp_tlast;

   // predicted unit state and configuration
   logic [63:0] word_bytes_m = '0;
   logic [3:0]  word_len_m   = '0;
   logic [63:0] repl_lo_m    = '0;
   logic [63:0] repl_hi_m    = '0;
   logic [4:0]  repl_len_m   = '0;
   int          limit_m      = -1;
   logic [7:0]  held_m [8];
   int          held_cnt_m   = 0;
   int          done_m       = 0;

   text_result_type expected_text[$];
   logic [7:0]   alphabet [3];
   bit           calm = 1'b0;

   int error_count            = 0;
   int requests_sent          = 0;
   int results_checked        = 0;
   int strings_closed         = 0;
   int replacements_predicted = 0;
   int csr_writes             = 0;

   limited_word_replace_stream_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] in_char
      .req_tlast  (req_tlast),   // end_of_string
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] out_char
      .rsp_tuser  (rsp_tuser),   // [0] is_terminator
      .rsp_tlast  (rsp_tlast)    // last_of_run
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Run timed out with %0d results still expected", expected_text.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
   endfunction

   function automatic logic [7:0] repl_byte(input int idx);
      if (idx < 8) begin
         return repl_lo_m[8*idx +: 8];
      end
      return repl_hi_m[8*(idx-8) +: 8];
   endfunction

   function automatic bit limit_open();
      return (limit_m < 0) || (done_m < limit_m);
   endfunction

   function automatic void apply_csr(input logic [CSR_ADDR_WIDTH-1:0] idx,
                                     input logic [63:0] data);
      logic signed [16:0] lim17;
      lim17 = $signed(data[16:0]);
      case (idx)
         REG_PATTERN_BYTES:   word_bytes_m = data;
         REG_PATTERN_LEN:     word_len_m   = data[3:0];
         REG_REPLACEMENT_LO:  repl_lo_m    = data;
         REG_REPLACEMENT_HI:  repl_hi_m    = data;
         REG_REPLACEMENT_LEN: repl_len_m   = data[4:0];
         REG_REPLACE_LIMIT:   limit_m      = int'(lim17);
         default: ;
      endcase
   endfunction

   // Work out the response bytes of one request and queue them.
   function automatic void predict_text(input logic [7:0] ch, input logic eos);
      logic [7:0]   q [9];
      text_result_type run[$];
      text_result_type tail;
      int           qn, head, rem, plen, rlen, i;
      bit           hit;
      plen = (word_len_m > 8) ? 8 : int'(word_len_m);
      rlen = (repl_len_m > 16) ? 16 : int'(repl_len_m);
      qn = (held_cnt_m > 7) ? 7 : held_cnt_m;
      for (i = 0; i < qn; i++) q[i] = held_m[i];
      q[qn] = ch;
      qn++;
      held_cnt_m = 0;
      if (plen == 0 || qn > plen || !limit_open()) begin
         for (i = 0; i < qn; i++) run.push_back(text_result_type'({q[i], 2'b00}));
      end else begin
         head = 0;
         while (head < qn) begin
            rem = qn - head;
            hit = 1'b1;
            for (i = 0; i < rem && hit; i++) begin
               if (q[head+i] != word_bytes_m[8*i +: 8]) hit = 1'b0;
            end
            if (hit && rem == plen) begin
               for (i = 0; i < rlen; i++) run.push_back(text_result_type'({repl_byte(i), 2'b00}));
               if (done_m < DONE_MAX) done_m++;
               replacements_predicted++;
               head = qn;
            end else if (hit) begin
               // hold the partial match for the next request
               for (i = 0; i < rem; i++) held_m[i] = q[head+i];
               held_cnt_m = rem;
               head = qn;
            end else begin
               // naive restart: drop the oldest byte and rescan
               run.push_back(text_result_type'({q[head], 2'b00}));
               head++;
            end
         end
      end
      if (eos) begin
         for (i = 0; i < held_cnt_m; i++) run.push_back(text_result_type'({held_m[i], 2'b00}));
         run.push_back(text_result_type'({8'h00, 2'b10}));
         held_cnt_m = 0;
         done_m = 0;
         strings_closed++;
      end
      if (run.size() > 0) begin
         tail = run.pop_back();
         tail.last = 1'b1;
         run.push_back(tail);
      end
      for (i = 0; i < run.size(); i++) expected_text.push_back(run[i]);
   endfunction

   always @(posedge clock) begin : check_results
      text_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (expected_text.size() == 0) begin
            flag_error($sformatf("unexpected result char=%02h term=%0b last=%0b",
                                 rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            want = expected_text.pop_front();
            if (rsp_tdata !== want.ch || rsp_tuser !== want.term || rsp_tlast !== want.last) begin
               flag_error($sformatf("expected char=%02h term=%0b last=%0b, got char=%02h term=%0b last=%0b",
                                    want.ch, want.term, want.last,
                                    rsp_tdata, rsp_tuser, rsp_tlast));
            end
         end
      end
   end

   // Response back-pressure in random bursts, none once calm is set.
   initial begin
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(0, 10)) @(posedge clock);
      end
   end

   task automatic send_char(input logic [7:0] ch, input logic eos);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      predict_text(ch, eos);
   endtask

   // Hold off requests until every predicted byte is back, then settle.
   task automatic wait_all_results();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (expected_text.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_text.size() != 0) begin
         flag_error($sformatf("%0d expected results never arrived", expected_text.size()));
         expected_text.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_WIDTH-1:0] idx, input logic [63:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      apply_csr(idx, data);
      csr_writes++;
   endtask

   task automatic check_reset_passthrough();
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);
   endtask

   task automatic check_restart_and_flush();
      wait_all_results();
      // word "aab"; the bytes above the length are don't-care
      write_csr(REG_PATTERN_BYTES, 64'hA5A5_A5A5_A562_6161);
      write_csr(REG_PATTERN_LEN, 64'd3);
      write_csr(REG_REPLACEMENT_LO, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(REG_REPLACEMENT_HI, 64'h0011_2233_4455_6677);
      write_csr(REG_REPLACEMENT_LEN, 64'd16);
      write_csr(REG_REPLACE_LIMIT, {47'd0, LIMIT_NONE});
      send_char(8'h61, 1'b0);
      send_char(8'h61, 1'b0);
      send_char(8'h61, 1'b0);
      send_char(8'h62, 1'b0);
      send_char(8'h61, 1'b1);
      // match completed by the last byte: replacement and terminator together
      send_char(8'h61, 1'b0);
      send_char(8'h61, 1'b0);
      send_char(8'h62, 1'b1);
   endtask

   task automatic check_full_length_word();
      int i;
      wait_all_results();
      write_csr(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(REG_PATTERN_LEN, 64'd15);
      write_csr(REG_REPLACEMENT_HI, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(REG_REPLACEMENT_LEN, 64'd31);
      for (i = 0; i < 8; i++) send_char(8'hFF, i == 7);
   endtask

   task automatic check_replace_limits();
      wait_all_results();
      write_csr(REG_PATTERN_BYTES, 64'h0000_0000_0000_0078);
      write_csr(REG_PATTERN_LEN, 64'd1);
      write_csr(REG_REPLACEMENT_LEN, 64'd0);
      write_csr(REG_REPLACE_LIMIT, 64'd1);
      send_char(8'h78, 1'b0);
      send_char(8'h78, 1'b0);
      send_char(8'h79, 1'b1);
      wait_all_results();
      write_csr(REG_REPLACE_LIMIT, 64'd0);
      send_char(8'h78, 1'b0);
      send_char(8'h78, 1'b1);
      wait_all_results();
      write_csr(REG_REPLACE_LIMIT, {47'd0, LIMIT_MOST_NEG});
      send_char(8'h78, 1'b1);
   endtask

   task automatic check_shortened_word();
      wait_all_results();
      write_csr(REG_PATTERN_BYTES, 64'h0000_0000_6463_6261);
      write_csr(REG_PATTERN_LEN, 64'd4);
      write_csr(REG_REPLACEMENT_LEN, 64'd2);
      write_csr(REG_REPLACE_LIMIT, {47'd0, LIMIT_NONE});
      send_char(8'h61, 1'b0);
      send_char(8'h62, 1'b0);
      send_char(8'h63, 1'b0);
      // three bytes held; shrink the word below that count
      wait_all_results();
      write_csr(REG_PATTERN_LEN, 64'd2);
      send_char(8'h64, 1'b1);
   endtask

   task automatic check_spare_indexes();
      wait_all_results();
      write_csr(SPARE_INDEX_LO, {$urandom, $urandom});
      write_csr(SPARE_INDEX_HI, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic configure_random();
      logic [63:0] data;
      logic [16:0] lim;
      int          i;
      wait_all_results();
      for (i = 0; i < 3; i++) alphabet[i] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
         alphabet[0] = 8'h00;
         alphabet[1] = 8'hFF;
      end
      for (i = 0; i < 8; i++) data[8*i +: 8] = alphabet[$urandom_range(0, 2)];
      write_csr(REG_PATTERN_BYTES, data);
      data = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       data[3:0] = 4'd0;
         1:       data[3:0] = 4'd8;
         2:       data[3:0] = 4'($urandom_range(9, 15));
         default: data[3:0] = 4'($urandom_range(1, 7));
      endcase
      write_csr(REG_PATTERN_LEN, data);
      write_csr(REG_REPLACEMENT_LO, {$urandom, $urandom});
      write_csr(REG_REPLACEMENT_HI, {$urandom, $urandom});
      data = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       data[4:0] = 5'd0;
         1:       data[4:0] = 5'd16;
         2:       data[4:0] = 5'($urandom_range(17, 31));
         default: data[4:0] = 5'($urandom_range(1, 15));
      endcase
      write_csr(REG_REPLACEMENT_LEN, data);
      case ($urandom_range(0, 7))
         1:       lim = 17'd0;
         2:       lim = 17'd1;
         3:       lim = 17'($urandom_range(2, 5));
         4:       lim = LIMIT_CEILING;
         5:       lim = LIMIT_MOST_NEG | 17'($urandom_range(0, 65534));
         default: lim = LIMIT_NONE;
      endcase
      data = {$urandom, $urandom};
      data[16:0] = lim;
      write_csr(REG_REPLACE_LIMIT, data);
   endtask

   task automatic check_random_mixes(input int count, input bit with_pause);
      logic [7:0] text[$];
      int         plen, pick, cut, i, k;
      configure_random();
      plen = (word_len_m > 8) ? 8 : int'(word_len_m);
      // mostly whole words and broken prefixes, some noise
      while (text.size() < count) begin
         pick = $urandom_range(0, 9);
         if (pick < 5 && plen > 0) begin
            for (i = 0; i < plen; i++) text.push_back(word_bytes_m[8*i +: 8]);
         end else if (pick < 7 && plen > 1) begin
            cut = $urandom_range(1, plen - 1);
            for (i = 0; i < cut; i++) text.push_back(word_bytes_m[8*i +: 8]);
            text.push_back(alphabet[$urandom_range(0, 2)]);
         end else if (pick < 9) begin
            text.push_back(alphabet[$urandom_range(0, 2)]);
         end else begin
            text.push_back(8'($urandom_range(0, 255)));
         end
      end
      for (k = 0; k < count; k++) begin
         if (with_pause && k == count / 2) wait_all_results();
         send_char(text[k], $urandom_range(0, 9) == 0);
      end
   endtask

   // Keep replacing under the largest positive limit.
   task automatic check_limit_ceiling();
      int k;
      wait_all_results();
      write_csr(REG_PATTERN_BYTES, 64'h0000_0000_0000_0041);
      write_csr(REG_PATTERN_LEN, 64'd1);
      write_csr(REG_REPLACEMENT_LO, 64'h0000_0000_0000_0078);
      write_csr(REG_REPLACEMENT_LEN, 64'd1);
      write_csr(REG_REPLACE_LIMIT, {47'd0, LIMIT_CEILING});
      for (k = 0; k < 8; k++) send_char(8'h41, 1'b0);
      send_char(8'h41, 1'b1);
   endtask

   initial begin
      int p;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_reset_passthrough();
      check_restart_and_flush();
      check_full_length_word();
      check_replace_limits();
      check_shortened_word();
      check_spare_indexes();
      for (p = 0; p < 6; p++) check_random_mixes(30, p == 1);
      calm = 1'b1;
      check_limit_ceiling();
      check_random_mixes(40, 1'b0);
      wait_all_results();
      $display("Covered %0d requests in %0d strings over %0d register writes;",
               requests_sent, strings_closed, csr_writes);
      $display("checked %0d response bytes, %0d word replacements predicted",
               results_checked, replacements_predicted);
      if (error_count == 0 && expected_text.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/lwr_pkg.sv
rtl/lwr_ctrl.sv
rtl/lwr_dp.sv
rtl/lwr_out.sv
rtl/limited_word_replace_stream_unit.sv
dv/tb.sv
